### hw/rtl/jpe_pkg.sv
package jpe_pkg;

  localparam int FRAC_BITS    = 40;
  localparam int MIN_EXPONENT = 2;
  localparam int MAX_EXPONENT = 8;
  localparam int COUNT_BITS   = 16;
  localparam int PORT_BITS    = 48;
  localparam int WORD_BITS    = 64;
  localparam int PROD_BITS    = 2 * WORD_BITS;
  localparam int EXP_BITS     = 4;
  localparam int INDEX_BITS   = 8;
  localparam int MUL_CELLS    = 4;
  localparam int ESCAPE_RADIUS_SQ = 16;

  // Register indexes of the configuration port.
  localparam logic [INDEX_BITS-1:0] REG_ITER_LIMIT = 8'd0;
  localparam logic [INDEX_BITS-1:0] REG_EXPONENT   = 8'd1;
  localparam logic [INDEX_BITS-1:0] REG_C_REAL     = 8'd2;
  localparam logic [INDEX_BITS-1:0] REG_C_IMAG     = 8'd3;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] PORT_MAX = 64'sd140737488355327;
  localparam logic signed [WORD_BITS-1:0] PORT_MIN = -64'sd140737488355328;

  // One slot of the multiplier chain.
  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;
    logic [PROD_BITS-1:0] acc;
  } mul_lane_t;

  typedef struct packed {
    logic                        valid;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                        valid;
    logic signed [WORD_BITS-1:0] res;
    logic [PROD_BITS-1:0]        full;
  } mul_rsp_t;

  function automatic logic signed [WORD_BITS-1:0] sat_add(
      input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS-1:0] r;
    r = a + b;
    if (a[WORD_BITS-1] == b[WORD_BITS-1] && r[WORD_BITS-1] != a[WORD_BITS-1])
      return a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
    return r;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_sub(
      input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS-1:0] r;
    r = a - b;
    if (a[WORD_BITS-1] != b[WORD_BITS-1] && r[WORD_BITS-1] != a[WORD_BITS-1])
      return a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
    return r;
  endfunction

  function automatic logic [PORT_BITS-1:0] sat_port(input logic signed [WORD_BITS-1:0] v);
    if (v > PORT_MAX) return PORT_MAX[PORT_BITS-1:0];
    if (v < PORT_MIN) return PORT_MIN[PORT_BITS-1:0];
    return v[PORT_BITS-1:0];
  endfunction

endpackage

### hw/rtl/jpe_in_if.sv
interface jpe_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] start_real;
  logic [47:0] start_imag;
  modport source (output valid, start_real, start_imag, input ready);
  modport sink (input valid, start_real, start_imag, output ready);
endinterface

### hw/rtl/jpe_out_if.sv
interface jpe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] iteration_count;
  logic        escaped;
  logic [47:0] power_real;
  logic [47:0] power_imag;
  modport source (output valid, iteration_count, escaped, power_real, power_imag,
                  input ready);
  modport sink (input valid, iteration_count, escaped, power_real, power_imag,
                output ready);
endinterface

### hw/rtl/jpe_cfg_if.sv
interface jpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/jpe_mul_cell.sv
module jpe_mul_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         step,
  input  jpe_pkg::mul_lane_t lane_in,
  output jpe_pkg::mul_lane_t lane_out
);
  import jpe_pkg::*;

  logic [31:0]          a_half;
  logic [31:0]          b_half;
  logic [63:0]          pp;
  logic [PROD_BITS-1:0] pp_shifted;

  // Each cell adds one 32x32 partial product and passes the slot on.
  always_comb begin
    a_half = step[1] ? lane_in.ma[63:32] : lane_in.ma[31:0];
    b_half = step[0] ? lane_in.mb[63:32] : lane_in.mb[31:0];
    pp     = 64'(a_half) * 64'(b_half);
    case (step) inside
      2'd0:       pp_shifted = {64'd0, pp};
      2'd1, 2'd2: pp_shifted = {32'd0, pp, 32'd0};
      default:    pp_shifted = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= lane_in.valid;
      lane_out.neg   <= lane_in.neg;
      lane_out.ma    <= lane_in.ma;
      lane_out.mb    <= lane_in.mb;
      lane_out.acc   <= lane_in.acc + pp_shifted;
    end
  end

endmodule

### hw/rtl/jpe_mul.sv
module jpe_mul (
  input  logic              clk,
  input  logic              rst,
  input  jpe_pkg::mul_req_t req,
  output jpe_pkg::mul_rsp_t rsp
);
  import jpe_pkg::*;

  mul_lane_t            lane_head;
  mul_lane_t            lane [0:MUL_CELLS];
  logic [PROD_BITS-1:0] rounded;
  logic [WORD_BITS-1:0] mag;
  logic                 ovf;

  // Operand magnitudes are registered before the partial-product chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_head.valid <= 1'b0;
    end else begin
      lane_head.valid <= req.valid;
      lane_head.neg   <= req.a[WORD_BITS-1] != req.b[WORD_BITS-1];
      lane_head.ma    <= req.a[WORD_BITS-1] ? WORD_BITS'(-req.a) : req.a;
      lane_head.mb    <= req.b[WORD_BITS-1] ? WORD_BITS'(-req.b) : req.b;
      lane_head.acc   <= '0;
    end
  end

  assign lane[0] = lane_head;

  for (genvar i = 0; i < MUL_CELLS; i++) begin : g_cell
    jpe_mul_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (2'(i)),
      .lane_in  (lane[i]),
      .lane_out (lane[i+1])
    );
  end

  // Round half away from zero to Q.40 and clamp the magnitude.
  always_comb begin
    rounded = lane[MUL_CELLS].acc + (PROD_BITS'(1) << (FRAC_BITS - 1));
    ovf     = |rounded[PROD_BITS-1:FRAC_BITS+WORD_BITS-1];
    mag     = ovf ? WORD_MAX : {1'b0, rounded[FRAC_BITS+WORD_BITS-2:FRAC_BITS]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= lane[MUL_CELLS].valid;
      rsp.res   <= lane[MUL_CELLS].neg ? WORD_BITS'(-mag) : mag;
      rsp.full  <= lane[MUL_CELLS].acc;
    end
  end

endmodule

### hw/rtl/julia_power_n_escape_time.sv
// Channel   Direction  Payload
// point     in         start_real, start_imag (Q8.40)
// result    out        iteration_count, escaped, power_real, power_imag
// cfg       in         index, data (write only, always ready)
//
// One point is worked at a time. All products go through one multiplier
// chain (operand register, partial-product cells, output register);
// independent products of a batch follow each other in consecutive cycles.
// An iteration is a radius test, then n - 1 complex products, and the
// final powers add n - 1 batches of two real products.
// Reset is synchronous and returns the control and configuration registers to their reset values.
// A waiting result does not block the next point from being taken.
module julia_power_n_escape_time (
  input  logic clk,
  input  logic rst,
  jpe_in_if.sink    point,
  jpe_out_if.source result,
  jpe_cfg_if.sink   cfg
);
  import jpe_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RADIUS, S_CMUL, S_POWER, S_FINISH} state_t;

  localparam logic [PROD_BITS:0] RADIUS_BOUND =
    (PROD_BITS+1)'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

  state_t state;

  // Configuration registers.
  logic [COUNT_BITS-1:0]       limit;
  logic [EXP_BITS-1:0]         exp_reg;
  logic signed [WORD_BITS-1:0] c_re;
  logic signed [WORD_BITS-1:0] c_im;

  // Working values: z, the running power p, and the final power accumulators.
  logic signed [WORD_BITS-1:0] wr, wi, pr, pi, accr, acci;
  logic [COUNT_BITS-1:0]       count;
  logic [EXP_BITS-1:0]         step;
  logic [2:0]                  issue_cnt;
  logic [1:0]                  coll_cnt;
  logic signed [WORD_BITS-1:0] r_res [0:2];
  logic [PROD_BITS-1:0]        full0;

  // Result register.
  logic                  out_valid;
  logic [COUNT_BITS-1:0] o_count;
  logic                  o_esc;
  logic [PORT_BITS-1:0]  o_pr, o_pi;

  logic [EXP_BITS-1:0]         n_eff;
  logic [2:0]                  batch_ops;
  logic                        done_batch;
  logic [PROD_BITS:0]          sq_sum;
  logic                        in_radius;
  logic signed [WORD_BITS-1:0] nr, ni;
  mul_req_t                    req;
  mul_rsp_t                    rsp;

  jpe_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign point.ready            = (state == S_IDLE);
  assign cfg.ready              = 1'b1;
  assign result.valid           = out_valid;
  assign result.iteration_count = o_count;
  assign result.escaped         = o_esc;
  assign result.power_real      = o_pr;
  assign result.power_imag      = o_pi;

  always_comb begin
    if (exp_reg < EXP_BITS'(MIN_EXPONENT))      n_eff = EXP_BITS'(MIN_EXPONENT);
    else if (exp_reg > EXP_BITS'(MAX_EXPONENT)) n_eff = EXP_BITS'(MAX_EXPONENT);
    else                                        n_eff = exp_reg;

    batch_ops  = (state == S_CMUL) ? 3'd4 : 3'd2;
    done_batch = rsp.valid && ({1'b0, coll_cnt} == batch_ops - 3'd1);

    // The radius test uses the exact squares, before rounding.
    sq_sum    = {1'b0, full0} + {1'b0, rsp.full};
    in_radius = sq_sum <= RADIUS_BOUND;
    nr        = sat_sub(r_res[0], r_res[1]);
    ni        = sat_add(r_res[2], rsp.res);

    req.valid = (state == S_RADIUS || state == S_CMUL || state == S_POWER) &&
                (issue_cnt < batch_ops);
    req.a = '0;
    req.b = '0;
    unique case (state)
      S_RADIUS: begin
        req.a = issue_cnt[0] ? wi : wr;
        req.b = issue_cnt[0] ? wi : wr;
      end
      S_CMUL: begin
        // Order: pr*wr, pi*wi, pr*wi, pi*wr.
        req.a = issue_cnt[0] ? pi : pr;
        req.b = (issue_cnt[0] ^ issue_cnt[1]) ? wi : wr;
      end
      S_POWER: begin
        req.a = issue_cnt[0] ? acci : accr;
        req.b = issue_cnt[0] ? wi : wr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      limit     <= COUNT_BITS'(64);
      exp_reg   <= EXP_BITS'(2);
      c_re      <= '0;
      c_im      <= '0;
      out_valid <= 1'b0;
      issue_cnt <= '0;
      coll_cnt  <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_ITER_LIMIT: limit   <= cfg.data[COUNT_BITS-1:0];
          REG_EXPONENT:   exp_reg <= cfg.data[EXP_BITS-1:0];
          REG_C_REAL:     c_re    <= {{(WORD_BITS-PORT_BITS){cfg.data[PORT_BITS-1]}}, cfg.data};
          REG_C_IMAG:     c_im    <= {{(WORD_BITS-PORT_BITS){cfg.data[PORT_BITS-1]}}, cfg.data};
          default: ;
        endcase
      end

      // In the finish state the result register is reloaded instead.
      if (result.valid && result.ready && state != S_FINISH) out_valid <= 1'b0;

      if (req.valid) issue_cnt <= issue_cnt + 3'd1;
      if (rsp.valid && !done_batch) begin
        r_res[coll_cnt] <= rsp.res;
        coll_cnt        <= coll_cnt + 2'd1;
        if (coll_cnt == 2'd0) full0 <= rsp.full;
      end
      if (done_batch) begin
        issue_cnt <= '0;
        coll_cnt  <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (point.valid) begin
            wr    <= {{(WORD_BITS-PORT_BITS){point.start_real[PORT_BITS-1]}}, point.start_real};
            wi    <= {{(WORD_BITS-PORT_BITS){point.start_imag[PORT_BITS-1]}}, point.start_imag};
            count <= '0;
            state <= S_RADIUS;
          end
        end
        S_RADIUS: begin
          if (done_batch) begin
            step <= EXP_BITS'(1);
            if (in_radius && count < limit) begin
              pr    <= wr;
              pi    <= wi;
              state <= S_CMUL;
            end else begin
              accr  <= wr;
              acci  <= wi;
              state <= S_POWER;
            end
          end
        end
        S_CMUL: begin
          if (done_batch) begin
            if (step + EXP_BITS'(1) == n_eff) begin
              wr    <= sat_add(nr, c_re);
              wi    <= sat_add(ni, c_im);
              count <= count + COUNT_BITS'(1);
              state <= S_RADIUS;
            end else begin
              pr   <= nr;
              pi   <= ni;
              step <= step + EXP_BITS'(1);
            end
          end
        end
        S_POWER: begin
          if (done_batch) begin
            accr <= r_res[0];
            acci <= rsp.res;
            if (step + EXP_BITS'(1) == n_eff) state <= S_FINISH;
            else step <= step + EXP_BITS'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            o_count   <= count;
            o_esc     <= count < limit;
            o_pr      <= sat_port(accr);
            o_pi      <= sat_port(acci);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Products only come back while a batch is being collected.
  a_rsp_in_batch: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (state == S_RADIUS || state == S_CMUL || state == S_POWER))
    else $error("multiplier result outside a batch");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> issue_cnt < batch_ops)
    else $error("too many products issued in a batch");

  a_collect_order: assert property (@(posedge clk) disable iff (rst)
    {1'b0, coll_cnt} <= issue_cnt)
    else $error("more products collected than issued");

endmodule

### dv/tb_julia_power_n_escape_time.sv
`timescale 1ns / 1ps

module tb_julia_power_n_escape_time;
  import jpe_pkg::*;

  typedef logic signed [WORD_BITS-1:0] q_t;

  // One expected result of the escape-time loop.
  typedef struct {
    logic [COUNT_BITS-1:0] count;
    logic                  escaped;
    logic [PORT_BITS-1:0]  pow_re;
    logic [PORT_BITS-1:0]  pow_im;
  } escape_outcome_t;

  // Escape-time predictor and result checker. It keeps its own copy of the
  // configuration registers and a queue of outcomes in arrival order.
  class escape_scoreboard;
    logic [COUNT_BITS-1:0] iter_limit = 16'd64;
    logic [EXP_BITS-1:0]   power_sel  = 4'd2;
    q_t                    c_re       = '0;
    q_t                    c_im       = '0;
    escape_outcome_t       pending[$];
    int                    n_errors   = 0;
    int                    n_checked  = 0;

    function q_t widen(logic [PORT_BITS-1:0] v);
      return {{(WORD_BITS-PORT_BITS){v[PORT_BITS-1]}}, v};
    endfunction

    function logic [PORT_BITS-1:0] clamp_port(q_t v);
      if (v > PORT_MAX) return PORT_MAX[PORT_BITS-1:0];
      if (v < PORT_MIN) return PORT_MIN[PORT_BITS-1:0];
      return v[PORT_BITS-1:0];
    endfunction

    function logic [WORD_BITS-1:0] abs_of(q_t v);
      return v[WORD_BITS-1] ? (~v + 64'd1) : v;
    endfunction

    // Exact product, rounded half away from zero to Q.40, magnitude saturated.
    function q_t mul_q40(q_t a, q_t b);
      logic [PROD_BITS-1:0] p;
      logic [WORD_BITS-1:0] mag;
      p = abs_of(a) * abs_of(b);
      p = p + (128'd1 << (FRAC_BITS - 1));
      if (|p[PROD_BITS-1:WORD_BITS+FRAC_BITS-1]) mag = WORD_MAX;
      else mag = {1'b0, p[WORD_BITS+FRAC_BITS-2:FRAC_BITS]};
      return (a[WORD_BITS-1] ^ b[WORD_BITS-1]) ? -mag : mag;
    endfunction

    function q_t add_sat(q_t a, q_t b);
      q_t r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) return a[63] ? WORD_MIN : WORD_MAX;
      return r;
    endfunction

    function q_t sub_sat(q_t a, q_t b);
      q_t r;
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) return a[63] ? WORD_MIN : WORD_MAX;
      return r;
    endfunction

    // |z|^2 <= 16, taken on the exact squares.
    function bit within_radius(q_t x, q_t y);
      logic [128:0] ax, ay, s;
      ax = abs_of(x);
      ay = abs_of(y);
      s = ax * ax + ay * ay;
      return s <= (129'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS));
    endfunction

    function q_t real_pow(q_t x, int n);
      q_t acc;
      acc = x;
      for (int k = 1; k < n; k++) acc = mul_q40(acc, x);
      return acc;
    endfunction

    function void note_point(logic [PORT_BITS-1:0] sr, logic [PORT_BITS-1:0] si);
      escape_outcome_t o;
      q_t zr, zi, pr, pim, nr, ni;
      int n, cnt;
      n = power_sel < MIN_EXPONENT ? MIN_EXPONENT :
          (power_sel > MAX_EXPONENT ? MAX_EXPONENT : int'(power_sel));
      zr = widen(sr);
      zi = widen(si);
      cnt = 0;
      while (within_radius(zr, zi) && cnt < int'(iter_limit)) begin
        pr = zr;
        pim = zi;
        for (int k = 1; k < n; k++) begin
          nr = sub_sat(mul_q40(pr, zr), mul_q40(pim, zi));
          ni = add_sat(mul_q40(pr, zi), mul_q40(pim, zr));
          pr = nr;
          pim = ni;
        end
        zr = add_sat(pr, c_re);
        zi = add_sat(pim, c_im);
        cnt++;
      end
      o.count   = cnt[COUNT_BITS-1:0];
      o.escaped = cnt < int'(iter_limit);
      o.pow_re  = clamp_port(real_pow(zr, n));
      o.pow_im  = clamp_port(real_pow(zi, n));
      pending.push_back(o);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, n_checked);
      n_errors++;
    endtask

    task check_result(logic [COUNT_BITS-1:0] cnt, logic esc,
                      logic [PORT_BITS-1:0] p_re, logic [PORT_BITS-1:0] p_im);
      escape_outcome_t o;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", {48'd0, cnt}, 64'd0);
        return;
      end
      o = pending.pop_front();
      if (cnt !== o.count) report_mismatch("iteration_count", 64'(cnt), 64'(o.count));
      if (esc !== o.escaped) report_mismatch("escaped", 64'(esc), 64'(o.escaped));
      if (p_re !== o.pow_re) report_mismatch("power_real", 64'(p_re), 64'(o.pow_re));
      if (p_im !== o.pow_im) report_mismatch("power_imag", 64'(p_im), 64'(o.pow_im));
      n_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  jpe_in_if  pin();
  jpe_out_if pout();
  jpe_cfg_if pcfg();

  julia_power_n_escape_time u_dut (
    .clk(clk),
    .rst(rst),
    .point(pin),
    .result(pout),
    .cfg(pcfg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  escape_scoreboard sb = new();

  // When quiet is set, neither side inserts idle cycles.
  bit quiet = 1'b0;
  int out_stall = 0;
  int cycles = 0;
  int points_sent = 0;
  int phases_run = 0;

  initial begin
    pin.valid = 1'b0;
    pin.start_real = '0;
    pin.start_imag = '0;
    pout.ready = 1'b0;
    pcfg.valid = 1'b0;
    pcfg.index = '0;
    pcfg.data = '0;
  end

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: check each accepted transaction, then choose the next ready.
  always @(posedge clk) begin
    if (!rst && pout.valid && pout.ready)
      sb.check_result(pout.iteration_count, pout.escaped, pout.power_real, pout.power_imag);
    if (rst) begin
      pout.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      pout.ready <= 1'b0;
    end else begin
      pout.ready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 12000000) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
      $display("tb_julia_power_n_escape_time: errors");
      $finish;
    end
  end

  // A register write; valid drops again afterwards since writes are rare.
  task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [PORT_BITS-1:0] val);
    pcfg.valid <= 1'b1;
    pcfg.index <= idx;
    pcfg.data  <= val;
    do @(posedge clk); while (!pcfg.ready);
    pcfg.valid <= 1'b0;
    case (idx)
      REG_ITER_LIMIT: sb.iter_limit = val[COUNT_BITS-1:0];
      REG_EXPONENT:   sb.power_sel  = val[EXP_BITS-1:0];
      REG_C_REAL:     sb.c_re       = sb.widen(val);
      REG_C_IMAG:     sb.c_im       = sb.widen(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] lim, input logic [3:0] ex,
                           input logic [47:0] cr, input logic [47:0] ci);
    write_reg(REG_ITER_LIMIT, {32'd0, lim});
    write_reg(REG_EXPONENT, {44'd0, ex});
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    phases_run++;
  endtask

  // Valid stays high between back-to-back points; it only drops ahead of a gap.
  task automatic send_point(input logic [47:0] re, input logic [47:0] im);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.valid <= 1'b1;
    pin.start_real <= re;
    pin.start_imag <= im;
    do @(posedge clk); while (!pin.ready);
    sb.note_point(re, im);
    points_sent++;
  endtask

  // Wait for every outstanding result, then a margin for the block to settle.
  task automatic drain();
    pin.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function logic [47:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  // Mostly points near the radius, some anywhere, a few at the port extremes.
  function logic [47:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $signed(rand48()) >>> 5;
    if (r < 8) return rand48();
    if (r == 8) return $signed(rand48()) >>> 6;
    case ($urandom_range(0, 3))
      0: return PORT_MAX[47:0];
      1: return PORT_MIN[47:0];
      2: return 48'd0;
      default: return 48'd4 << FRAC_BITS;
    endcase
  endfunction

  function logic [47:0] pick_c();
    if ($urandom_range(0, 7) == 0) return rand48();
    return $signed(rand48()) >>> 7;
  endfunction

  localparam logic [47:0] ONE_Q  = 48'd1 << FRAC_BITS;
  localparam logic [47:0] FOUR_Q = 48'd4 << FRAC_BITS;

  initial begin
    logic [15:0] lim;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: limit 64, square, c at zero.
    send_point(48'd0, 48'd0);             // never escapes, runs the full limit
    send_point(FOUR_Q, 48'd0);            // exactly on the radius, still inside
    send_point(FOUR_Q + 48'd1, 48'd0);    // just outside: no iteration at all
    send_point(PORT_MAX[47:0], PORT_MAX[47:0]);
    send_point(PORT_MIN[47:0], PORT_MIN[47:0]);
    send_point(PORT_MIN[47:0], 48'd0);
    send_point(ONE_Q >> 1, -(ONE_Q >> 1));
    send_point(-ONE_Q, 48'd0);
    drain();

    // A zero limit with an exponent below range.
    configure(16'd0, 4'd0, ONE_Q >> 2, -(ONE_Q >> 2));
    send_point(48'd0, 48'd0);
    send_point(PORT_MAX[47:0], 48'd0);
    send_point(ONE_Q, ONE_Q);
    drain();

    // Single iteration, exponent one, c at both port extremes.
    configure(16'd1, 4'd1, PORT_MAX[47:0], PORT_MIN[47:0]);
    send_point(48'd0, 48'd0);
    send_point(ONE_Q, -ONE_Q);
    send_point(PORT_MIN[47:0], PORT_MAX[47:0]);
    drain();

    // Largest limit and exponent above range; the huge c ends every loop quickly.
    configure(16'hFFFF, 4'hF, PORT_MIN[47:0], PORT_MAX[47:0]);
    send_point(48'd0, 48'd0);
    send_point(FOUR_Q, FOUR_Q);
    send_point(ONE_Q, 48'd0);
    drain();

    // Exponent just above the maximum, modest c.
    configure(16'd9, 4'd9, -(ONE_Q >> 1), ONE_Q >> 3);
    send_point(48'd0, 48'd0);
    send_point(ONE_Q >> 1, ONE_Q >> 1);
    drain();

    // Random phases: new settings each time, small limits to keep the run short.
    for (int ph = 0; ph < 23; ph++) begin
      quiet = (ph % 4 == 1);
      lim = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 3)) :
            16'($urandom_range(1, 16));
      configure(lim, 4'($urandom_range(0, 15)), pick_c(), pick_c());
      for (int i = 0; i < 50; i++) begin
        // In every third phase, hold off once until the result side has caught up.
        if (i == 25 && ph % 3 == 0) drain();
        send_point(pick_coord(), pick_coord());
      end
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d points over %0d register settings, %0d results checked",
             points_sent, phases_run, sb.n_checked);
    $display("exponents 0..15, limits 0..65535, c and start points at the port extremes");
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("tb_julia_power_n_escape_time: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_errors, sb.pending.size());
      $display("tb_julia_power_n_escape_time: errors");
    end
    $finish;
  end

endmodule
